// ===== design/phase_current_clarke_park_unit_assert.svh =====
// Assertion macros for the phase-current Clarke/Park unit
`ifndef PHASE_CURRENT_CLARKE_PARK_UNIT_ASSERT_SVH
`define PHASE_CURRENT_CLARKE_PARK_UNIT_ASSERT_SVH

// hold expr at every edge outside reset
`define PCCP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// hold post in the same cycle whenever pre is true
`define PCCP_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/pccp_pkg.sv =====
package pccp_pkg;

  localparam int DUTY_W   = 16;
  localparam int SECTOR_W = 3;

  typedef logic [SECTOR_W-1:0] sector_t;

  localparam sector_t SECTOR_1 = 3'd1;
  localparam sector_t SECTOR_2 = 3'd2;
  localparam sector_t SECTOR_3 = 3'd3;
  localparam sector_t SECTOR_6 = 3'd6;

  localparam logic [DUTY_W-1:0] THR_RESET = 16'hFFFF;

  // quarter-wave sine polynomial, Q30
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  // 1/sqrt(3), Q30
  localparam logic [29:0] INV_SQRT3 = 30'd619925131;

endpackage

// ===== design/phase_current_clarke_park_unit.sv =====
// Channel  | Direction | Word fields
// in_      | slave     | phase_a/b/c, duty_a/b/c, vector_sector, elec_angle
// out_     | master    | alpha, beta, direct, quadrature, signed magnitude
// cfg_     | write     | drop_threshold
//
// One word accepted per clock while the output is not stalled; the pipeline has
// nine arithmetic stages, one square-root stage per result bit and the
// output register. A stalled output fills bubbles upstream before in_tready falls.
// rst_n clears the valid bits and sets drop_threshold to full scale.
`include "phase_current_clarke_park_unit_assert.svh"

module phase_current_clarke_park_unit #(
  parameter int CURRENT_WIDTH      = 16,
  parameter int ANGLE_WIDTH        = 16,
  parameter int TRIG_FRACTION_BITS = 15,
  localparam int IN_W  = ((3 * CURRENT_WIDTH + 3 * pccp_pkg::DUTY_W + pccp_pkg::SECTOR_W
                           + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((5 * (CURRENT_WIDTH + 2) + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pccp_pkg::DUTY_W-1:0] cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // phase_a, phase_b, phase_c, duty_a, duty_b, duty_c, vector_sector, elec_angle
  input  logic [IN_W-1:0]             in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // alpha_current, beta_current, direct_current, quadrature_current, signed_magnitude
  output logic [OUT_W-1:0]            out_tdata
);
  import pccp_pkg::*;

  localparam int CW  = CURRENT_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int TF  = TRIG_FRACTION_BITS;
  localparam int OW  = CW + 2;
  localparam int AB  = CW + 2;
  localparam int NW3 = CW + 3;
  localparam int MW  = CW + 2;
  localparam int DS  = CW + 4;
  localparam int K3W = CW + 3;
  localparam int SSW = CW + 4;
  localparam int BPW = SSW + 30;
  localparam int TW  = TF + 2;
  localparam int PW  = AB + TW;
  localparam int DW  = PW + 1;
  localparam int RW  = CW + 2;
  localparam int NQ  = 2 * RW;
  localparam int NS  = 10 + RW;
  localparam int PL  = AW - 1;
  localparam int XSH = 32 - AW;
  localparam int OFS_D = 3 * CW;
  localparam int OFS_S = OFS_D + 3 * DUTY_W;
  localparam int OFS_G = OFS_S + SECTOR_W;

  localparam logic [K3W-1:0] K3 = K3W'(((64'd1 << DS) + 64'd2) / 64'd3);
  localparam logic [PL-1:0]  QLEN = PL'(1) << (AW - 2);
  localparam logic [31:0]    RND32 = 32'd1 << (29 - TF);
  localparam logic [31:0]    ONE32 = 32'd1 << TF;
  localparam logic [BPW-1:0] HALF30 = BPW'(1) << 29;
  localparam logic signed [OW-1:0] OMAX = {1'b0, {(OW - 1){1'b1}}};
  localparam logic signed [OW-1:0] OMIN = {1'b1, {(OW - 1){1'b0}}};

  typedef struct packed {
    logic [NQ-1:0]          n;
    logic [RW-1:0]          root;
    logic [RW:0]            rem;
    logic signed [OW-1:0]   a;
    logic signed [OW-1:0]   beta;
    logic signed [OW-1:0]   d;
    logic signed [OW-1:0]   q;
  } sq_t;

  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [DW-1:0] v);
    logic [DW-1:0]     m;
    logic [DW-1:0]     r;
    logic signed [DW:0] sv;
    m  = v[DW-1] ? DW'(-v) : DW'(v);
    r  = (m + (DW'(1) << (TF - 1))) >> TF;
    sv = v[DW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (sv > (DW + 1)'(OMAX)) begin
      rnd_sat = OMAX;
    end else if (sv < (DW + 1)'(OMIN)) begin
      rnd_sat = OMIN;
    end else begin
      rnd_sat = sv[OW-1:0];
    end
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t           o;
    logic [RW+2:0] rs;
    logic [RW+2:0] tr;
    logic [RW+2:0] df;
    o   = s;
    rs  = {s.rem, s.n[NQ-1 -: 2]};
    tr  = (RW + 3)'({s.root, 2'b01});
    df  = rs - tr;
    o.n = s.n << 2;
    if (rs >= tr) begin
      o.rem  = df[RW:0];
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = rs[RW:0];
      o.root = {s.root[RW-2:0], 1'b0};
    end
    sq_step = o;
  endfunction

  logic [DUTY_W-1:0] thr_r;
  logic [NS-1:0]     v_r;
  logic [NS-1:0]     en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  // stage 1: unpack, sums, phase rebuild, angle fold
  logic signed [CW-1:0]  pa, pb, pc;
  logic [DUTY_W-1:0]     da, db, dc;
  sector_t               sec;
  logic [AW-1:0]         ang;
  logic signed [AB-1:0]  pa2, pb2, pc2;
  logic signed [NW3-1:0] pa3, pb3, pc3;
  logic [1:0]            quad, quadc;
  logic [AW-3:0]         pos;
  logic                  drop_nxt;
  logic signed [NW3-1:0] na_nxt, nb_nxt;
  logic signed [AB-1:0]  ad_nxt, bd_nxt;
  logic [PL-1:0]         p_nxt [2];
  logic                  neg_nxt [2];

  assign pa  = $signed(in_tdata[CW-1:0]);
  assign pb  = $signed(in_tdata[2*CW-1:CW]);
  assign pc  = $signed(in_tdata[3*CW-1:2*CW]);
  assign da  = in_tdata[OFS_D +: DUTY_W];
  assign db  = in_tdata[OFS_D + DUTY_W +: DUTY_W];
  assign dc  = in_tdata[OFS_D + 2 * DUTY_W +: DUTY_W];
  assign sec = in_tdata[OFS_S +: SECTOR_W];
  assign ang = in_tdata[OFS_G +: AW];

  assign pa2 = $signed({{2{pa[CW-1]}}, pa});
  assign pb2 = $signed({{2{pb[CW-1]}}, pb});
  assign pc2 = $signed({{2{pc[CW-1]}}, pc});
  assign pa3 = $signed({{3{pa[CW-1]}}, pa});
  assign pb3 = $signed({{3{pb[CW-1]}}, pb});
  assign pc3 = $signed({{3{pc[CW-1]}}, pc});

  assign drop_nxt = (da > thr_r) || (db > thr_r) || (dc > thr_r);
  assign na_nxt   = pa3 + pa3 - pb3 - pc3;
  assign nb_nxt   = pb3 + pb3 - pa3 - pc3;

  always_comb begin
    case (sec)
      SECTOR_1, SECTOR_6: begin
        ad_nxt = -pb2 - pc2;
        bd_nxt = pb2;
      end
      SECTOR_2, SECTOR_3: begin
        ad_nxt = pa2;
        bd_nxt = -pa2 - pc2;
      end
      default: begin
        ad_nxt = pa2;
        bd_nxt = pb2;
      end
    endcase
  end

  assign quad       = ang[AW-1 -: 2];
  assign quadc      = quad + 2'd1;
  assign pos        = ang[AW-3:0];
  assign p_nxt[0]   = quad[0] ? (QLEN - PL'(pos)) : PL'(pos);
  assign p_nxt[1]   = quadc[0] ? (QLEN - PL'(pos)) : PL'(pos);
  assign neg_nxt[0] = quad[1];
  assign neg_nxt[1] = quadc[1];

  logic                  s1_drop_r;
  logic signed [NW3-1:0] s1_na_r, s1_nb_r;
  logic signed [AB-1:0]  s1_ad_r, s1_bd_r;
  logic [PL-1:0]         s1_p_r [2];
  logic                  s1_neg_r [2];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_drop_r <= drop_nxt;
      s1_na_r   <= na_nxt;
      s1_nb_r   <= nb_nxt;
      s1_ad_r   <= ad_nxt;
      s1_bd_r   <= bd_nxt;
      s1_p_r    <= p_nxt;
      s1_neg_r  <= neg_nxt;
    end
  end

  // stage 2: divide by three, x squared
  logic [NW3-1:0]     absa, absb;
  logic [MW-1:0]      ma, mb;
  logic [MW+K3W-1:0]  pda_nxt, pdb_nxt;
  logic [30:0]        x_nxt [2];
  logic [61:0]        xxp [2];
  logic [30:0]        x2_nxt [2];

  assign absa    = s1_na_r[NW3-1] ? NW3'(-s1_na_r) : NW3'(s1_na_r);
  assign absb    = s1_nb_r[NW3-1] ? NW3'(-s1_nb_r) : NW3'(s1_nb_r);
  assign ma      = absa[MW-1:0] + MW'(1);
  assign mb      = absb[MW-1:0] + MW'(1);
  assign pda_nxt = (MW + K3W)'(ma) * (MW + K3W)'(K3);
  assign pdb_nxt = (MW + K3W)'(mb) * (MW + K3W)'(K3);

  logic                 s2_drop_r, s2_sa_r, s2_sb_r;
  logic [MW+K3W-1:0]    s2_pda_r, s2_pdb_r;
  logic signed [AB-1:0] s2_ad_r, s2_bd_r;
  logic [30:0]          s2_x_r [2];
  logic [30:0]          s2_x2_r [2];
  logic                 s2_neg_r [2];

  // stage 3: signed quotient, select; sine inner term
  logic [AB-1:0]        qa, qb;
  logic signed [AB-1:0] am, bm;
  logic signed [AB-1:0] a3_nxt, b3_nxt;
  logic [57:0]          cxp [2];
  logic [29:0]          inner_nxt [2];

  assign qa     = {1'b0, s2_pda_r[DS +: CW+1]};
  assign qb     = {1'b0, s2_pdb_r[DS +: CW+1]};
  assign am     = s2_sa_r ? -$signed(qa) : $signed(qa);
  assign bm     = s2_sb_r ? -$signed(qb) : $signed(qb);
  assign a3_nxt = s2_drop_r ? s2_ad_r : am;
  assign b3_nxt = s2_drop_r ? s2_bd_r : bm;

  logic signed [AB-1:0] s3_a_r, s3_b_r;
  logic [30:0]          s3_x_r [2];
  logic [30:0]          s3_x2_r [2];
  logic [29:0]          s3_inner_r [2];
  logic                 s3_neg_r [2];

  // stage 4: a + 2b; sine t term
  logic signed [SSW-1:0] s_nxt;
  logic [60:0]           ipd [2];
  logic [30:0]           t_nxt [2];

  assign s_nxt = SSW'(s3_a_r) + SSW'(s3_b_r) + SSW'(s3_b_r);

  logic signed [AB-1:0]  s4_a_r;
  logic signed [SSW-1:0] s4_s_r;
  logic [30:0]           s4_x_r [2];
  logic [30:0]           s4_t_r [2];
  logic                  s4_neg_r [2];

  // stage 5: beta product; sine x*t
  logic [SSW-1:0] sabs;
  logic [BPW-1:0] bp_nxt;
  logic [61:0]    rp [2];
  logic [30:0]    r_nxt [2];

  assign sabs   = s4_s_r[SSW-1] ? SSW'(-s4_s_r) : SSW'(s4_s_r);
  assign bp_nxt = BPW'(sabs) * BPW'(INV_SQRT3);

  logic signed [AB-1:0] s5_a_r;
  logic [BPW-1:0]       s5_bp_r;
  logic                 s5_sg_r;
  logic [30:0]          s5_r_r [2];
  logic                 s5_neg_r [2];

  // stage 6: round beta, round and clip sine/cosine
  logic [BPW-1:0]        bsum;
  logic [AB-1:0]         bmag;
  logic signed [AB-1:0]  beta_nxt;
  logic [31:0]           rr [2];
  logic [31:0]           rr2 [2];
  logic [TF:0]           tv [2];
  logic signed [TW-1:0]  tr_nxt [2];

  assign bsum     = s5_bp_r + HALF30;
  assign bmag     = bsum[30 +: AB];
  assign beta_nxt = s5_sg_r ? -$signed(bmag) : $signed(bmag);

  logic signed [AB-1:0] s6_a_r, s6_b_r;
  logic signed [TW-1:0] s6_t_r [2];

  for (genvar g = 0; g < 2; g++) begin : g_trig
    assign x_nxt[g]     = 31'(s1_p_r[g]) << XSH;
    assign xxp[g]       = 62'(x_nxt[g]) * 62'(x_nxt[g]);
    assign cxp[g]       = 58'(SIN_C) * 58'(s2_x2_r[g]);
    assign inner_nxt[g] = SIN_B - 30'(cxp[g][57:30]);
    assign ipd[g]       = 61'(s3_x2_r[g]) * 61'(s3_inner_r[g]);
    assign t_nxt[g]     = SIN_A - ipd[g][60:30];
    assign rp[g]        = 62'(s4_x_r[g]) * 62'(s4_t_r[g]);
    assign r_nxt[g]     = rp[g][60:30];
    assign rr[g]        = 32'(s5_r_r[g]) + RND32;
    assign rr2[g]       = rr[g] >> (30 - TF);
    assign tv[g]        = (rr2[g] > ONE32) ? ONE32[TF:0] : rr2[g][TF:0];
    assign tr_nxt[g]    = s5_neg_r[g] ? -$signed(TW'(tv[g])) : $signed(TW'(tv[g]));
    assign x2_nxt[g]    = xxp[g][60:30];

    always_ff @(posedge clk) begin
      if (en[1]) begin
        s2_x_r[g]   <= x_nxt[g];
        s2_x2_r[g]  <= x2_nxt[g];
        s2_neg_r[g] <= s1_neg_r[g];
      end
      if (en[2]) begin
        s3_x_r[g]     <= s2_x_r[g];
        s3_x2_r[g]    <= s2_x2_r[g];
        s3_inner_r[g] <= inner_nxt[g];
        s3_neg_r[g]   <= s2_neg_r[g];
      end
      if (en[3]) begin
        s4_x_r[g]   <= s3_x_r[g];
        s4_t_r[g]   <= t_nxt[g];
        s4_neg_r[g] <= s3_neg_r[g];
      end
      if (en[4]) begin
        s5_r_r[g]   <= r_nxt[g];
        s5_neg_r[g] <= s4_neg_r[g];
      end
      if (en[5]) begin
        s6_t_r[g] <= tr_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_drop_r <= s1_drop_r;
      s2_sa_r   <= s1_na_r[NW3-1];
      s2_sb_r   <= s1_nb_r[NW3-1];
      s2_pda_r  <= pda_nxt;
      s2_pdb_r  <= pdb_nxt;
      s2_ad_r   <= s1_ad_r;
      s2_bd_r   <= s1_bd_r;
    end
    if (en[2]) begin
      s3_a_r <= a3_nxt;
      s3_b_r <= b3_nxt;
    end
    if (en[3]) begin
      s4_a_r <= s3_a_r;
      s4_s_r <= s_nxt;
    end
    if (en[4]) begin
      s5_a_r  <= s4_a_r;
      s5_bp_r <= bp_nxt;
      s5_sg_r <= s4_s_r[SSW-1];
    end
    if (en[5]) begin
      s6_a_r <= s5_a_r;
      s6_b_r <= beta_nxt;
    end
  end

  // stage 7: squares and Park products
  logic signed [NQ-1:0] sqa_nxt, sqb_nxt;
  logic signed [PW-1:0] pac_nxt, pbs_nxt, pbc_nxt, pas_nxt;

  assign sqa_nxt = NQ'(s6_a_r) * NQ'(s6_a_r);
  assign sqb_nxt = NQ'(s6_b_r) * NQ'(s6_b_r);
  assign pac_nxt = PW'(s6_a_r) * PW'(s6_t_r[1]);
  assign pbs_nxt = PW'(s6_b_r) * PW'(s6_t_r[0]);
  assign pbc_nxt = PW'(s6_b_r) * PW'(s6_t_r[1]);
  assign pas_nxt = PW'(s6_a_r) * PW'(s6_t_r[0]);

  logic signed [AB-1:0] s7_a_r, s7_b_r;
  logic signed [NQ-1:0] s7_sqa_r, s7_sqb_r;
  logic signed [PW-1:0] s7_pac_r, s7_pbs_r, s7_pbc_r, s7_pas_r;

  // stage 8: d and q sums, sum of squares
  logic signed [DW-1:0] ds_nxt, qs_nxt;
  logic [NQ-1:0]        n2_nxt;

  assign ds_nxt = DW'(s7_pac_r) + DW'(s7_pbs_r);
  assign qs_nxt = DW'(s7_pbc_r) - DW'(s7_pas_r);
  assign n2_nxt = $unsigned(s7_sqa_r) + $unsigned(s7_sqb_r);

  logic signed [AB-1:0] s8_a_r, s8_b_r;
  logic signed [DW-1:0] s8_ds_r, s8_qs_r;
  logic [NQ-1:0]        s8_n2_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_a_r   <= s6_a_r;
      s7_b_r   <= s6_b_r;
      s7_sqa_r <= sqa_nxt;
      s7_sqb_r <= sqb_nxt;
      s7_pac_r <= pac_nxt;
      s7_pbs_r <= pbs_nxt;
      s7_pbc_r <= pbc_nxt;
      s7_pas_r <= pas_nxt;
    end
    if (en[7]) begin
      s8_a_r  <= s7_a_r;
      s8_b_r  <= s7_b_r;
      s8_ds_r <= ds_nxt;
      s8_qs_r <= qs_nxt;
      s8_n2_r <= n2_nxt;
    end
  end

  // stage 9 and square root: one root bit per stage
  sq_t sq_r [RW+1];
  sq_t sq0_nxt;

  always_comb begin
    sq0_nxt.n    = s8_n2_r;
    sq0_nxt.root = '0;
    sq0_nxt.rem  = '0;
    sq0_nxt.a    = s8_a_r;
    sq0_nxt.beta = s8_b_r;
    sq0_nxt.d    = rnd_sat(s8_ds_r);
    sq0_nxt.q    = rnd_sat(s8_qs_r);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en[8+j]) begin
        sq_r[j] <= sq_step(sq_r[j-1]);
      end
    end
  end

  // output stage: round root, sign by q, saturate
  logic [RW:0]            mg;
  logic signed [RW+1:0]   smv;
  logic signed [OW-1:0]   mag_nxt;

  assign mg  = (RW + 1)'(sq_r[RW].root)
               + (((sq_r[RW].rem > (RW + 1)'(sq_r[RW].root))) ? (RW + 1)'(1) : '0);
  assign smv = (sq_r[RW].q > 0) ? $signed({1'b0, mg}) : -$signed({1'b0, mg});

  always_comb begin
    if (smv > (RW + 2)'(OMAX)) begin
      mag_nxt = OMAX;
    end else if (smv < (RW + 2)'(OMIN)) begin
      mag_nxt = OMIN;
    end else begin
      mag_nxt = smv[OW-1:0];
    end
  end

  logic signed [OW-1:0] out_a_r, out_b_r, out_d_r, out_q_r, out_m_r;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_a_r <= sq_r[RW].a;
      out_b_r <= sq_r[RW].beta;
      out_d_r <= sq_r[RW].d;
      out_q_r <= sq_r[RW].q;
      out_m_r <= mag_nxt;
    end
  end

  assign out_tdata = OUT_W'({out_m_r, out_q_r, out_d_r, out_b_r, out_a_r});

  `PCCP_ASSERT_IMPLY(a_ready_when_empty, !out_tvalid, in_tready, "ready low with output empty")
  `PCCP_ASSERT_IMPLY(a_ready_on_take, out_tvalid && out_tready, in_tready, "ready low on take")
  `PCCP_ASSERT_IMPLY(a_mag_sign, out_tvalid && !(out_q_r > 0), !(out_m_r > 0), "magnitude sign")

endmodule
